// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  // Depth of each transaction queue and the width of its pointers.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Raw function codes on the input channel.
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  // Number of bits in one byte transfer.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Reset value of the delay unit length.
  localparam logic [7:0] UNIT_TICKS_RST = 8'd1;

  // Decoded command.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_READ,
    CMD_STOP
  } cmd_t;

  // Engine phases.
  typedef enum logic [14:0] {
    PH_IDLE   = 15'h0001,
    PH_ST_SDA = 15'h0002,
    PH_ST_SCL = 15'h0004,
    PH_TX_SET = 15'h0008,
    PH_TX_HI1 = 15'h0010,
    PH_TX_HI2 = 15'h0020,
    PH_TX_LO  = 15'h0040,
    PH_RX_SET = 15'h0080,
    PH_RX_UP  = 15'h0100,
    PH_RX_WT  = 15'h0200,
    PH_RX_LO  = 15'h0400,
    PH_SP_SDA = 15'h0800,
    PH_SP_HI1 = 15'h1000,
    PH_SP_HI2 = 15'h2000,
    PH_SP_END = 15'h4000
  } phase_t;

  // One classified input transaction.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       send_nack;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_bit;
  } result_t;

  // Map a raw function code onto a command; unused codes mean no command.
  function automatic cmd_t decode_func(input logic [2:0] func);
    cmd_t c;
    unique case (func)
      FUNC_START: c = CMD_START;
      FUNC_WRITE: c = CMD_WRITE;
      FUNC_READ:  c = CMD_READ;
      FUNC_STOP:  c = CMD_STOP;
      default:    c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/i2cm_front.sv -----
// Front end: accepts input transactions, decodes the command, queues them.
module i2cm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      func,
  input  logic [7:0]      data_byte,
  input  logic            send_nack,
  input  logic            scl_in,
  input  logic            sda_in,
  output logic            item_valid,
  output i2cm_pkg::item_t item,
  input  logic            item_take
);
  import i2cm_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              wr_en;
  logic              rd_en;
  item_t             wr_item;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;
  assign item       = mem_r[rd_ptr_r];

  // Classify the incoming transaction
  always_comb begin
    wr_item.cmd       = decode_func(func);
    wr_item.data_byte = data_byte;
    wr_item.send_nack = send_nack;
    wr_item.scl_in    = scl_in;
    wr_item.sda_in    = sda_in;
  end

  // Store the transaction
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/i2cm_engine.sv -----
// Back end: the bus phase sequencer, one queued transaction per step.
module i2cm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              item_valid,
  input  i2cm_pkg::item_t   item,
  output logic              item_take,
  input  logic              res_ready,
  output logic              res_push,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  logic [7:0] unit_ticks_r;
  phase_t     phase_r,     phase_nxt;
  logic [7:0] unit_cnt_r,  unit_cnt_nxt;
  logic [3:0] bit_idx_r,   bit_idx_nxt;
  logic [7:0] shift_r,     shift_nxt;
  logic       nack_r,      nack_nxt;
  logic       scl_drv_r,   scl_drv_nxt;
  logic       sda_drv_r,   sda_drv_nxt;
  logic       ack_r,       ack_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic [7:0] rx_byte_r,   rx_byte_nxt;

  logic       step;
  logic       go;
  phase_t     tgt;
  logic       done;
  logic [7:0] ticks;
  logic [8:0] cnt_sum;
  logic [3:0] bit_inc;
  logic       tx_bit;

  assign step      = item_valid && res_ready;
  assign item_take = step;
  assign res_push  = step;
  assign ticks     = (unit_ticks_r == '0) ? 8'd1 : unit_ticks_r;
  assign cnt_sum   = {1'b0, unit_cnt_r} + 9'd1;
  assign bit_inc   = bit_idx_r + 4'd1;

  // Hold the delay unit length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
    end else if (cfg_wr_en) begin
      unit_ticks_r <= cfg_wr_data;
    end
  end

  // Next state of the sequencer for one step
  always_comb begin
    phase_nxt     = phase_r;
    unit_cnt_nxt  = unit_cnt_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    nack_nxt      = nack_r;
    scl_drv_nxt   = scl_drv_r;
    sda_drv_nxt   = sda_drv_r;
    ack_nxt       = ack_r;
    read_mode_nxt = read_mode_r;
    rx_byte_nxt   = rx_byte_r;
    go            = 1'b0;
    tgt           = PH_IDLE;
    done          = 1'b0;
    tx_bit        = 1'b0;

    if (step) begin
      unique case (phase_r)
        // Launch a new command
        PH_IDLE: begin
          case (item.cmd)
            CMD_START: begin
              go  = 1'b1;
              tgt = PH_ST_SDA;
            end
            CMD_WRITE: begin
              read_mode_nxt = 1'b0;
              shift_nxt     = item.data_byte;
              bit_idx_nxt   = '0;
              go            = 1'b1;
              tgt           = PH_TX_SET;
            end
            CMD_READ: begin
              read_mode_nxt = 1'b1;
              shift_nxt     = '0;
              bit_idx_nxt   = '0;
              nack_nxt      = item.send_nack;
              go            = 1'b1;
              tgt           = PH_RX_SET;
            end
            CMD_STOP: begin
              go  = 1'b1;
              tgt = PH_SP_SDA;
            end
            default: ;
          endcase
        end
        // Wait for SCL high, then sample SDA
        PH_RX_WT: begin
          if (item.scl_in) begin
            if (read_mode_r) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
            end else begin
              ack_nxt = item.sda_in;
            end
            go  = 1'b1;
            tgt = PH_RX_LO;
          end
        end
        // Timed phases: count one unit, then move on
        default: begin
          if (cnt_sum >= {1'b0, ticks}) begin
            go = 1'b1;
            unique case (phase_r)
              PH_ST_SDA: tgt = PH_ST_SCL;
              PH_ST_SCL: begin
                tgt  = PH_IDLE;
                done = 1'b1;
              end
              PH_TX_SET: tgt = PH_TX_HI1;
              PH_TX_HI1: tgt = PH_TX_HI2;
              PH_TX_HI2: tgt = PH_TX_LO;
              PH_TX_LO: begin
                if (read_mode_r) begin
                  rx_byte_nxt = shift_r;
                  tgt         = PH_IDLE;
                  done        = 1'b1;
                end else begin
                  shift_nxt   = {shift_r[6:0], 1'b0};
                  bit_idx_nxt = bit_inc;
                  tgt         = (bit_inc < BYTE_BITS) ? PH_TX_SET : PH_RX_SET;
                end
              end
              PH_RX_SET: tgt = PH_RX_UP;
              PH_RX_UP:  tgt = PH_RX_WT;
              PH_RX_LO: begin
                if (read_mode_r) begin
                  bit_idx_nxt = bit_inc;
                  tgt         = (bit_inc < BYTE_BITS) ? PH_RX_SET : PH_TX_SET;
                end else begin
                  tgt  = PH_IDLE;
                  done = 1'b1;
                end
              end
              PH_SP_SDA: tgt = PH_SP_HI1;
              PH_SP_HI1: tgt = PH_SP_HI2;
              PH_SP_HI2: tgt = PH_SP_END;
              PH_SP_END: begin
                tgt  = PH_IDLE;
                done = 1'b1;
              end
              default:   tgt = PH_IDLE;
            endcase
          end else begin
            unit_cnt_nxt = cnt_sum[7:0];
          end
        end
      endcase

      // Enter the target phase and set the line drivers
      if (go) begin
        phase_nxt    = tgt;
        unit_cnt_nxt = '0;
        tx_bit       = read_mode_nxt ? nack_nxt : shift_nxt[7];
        unique case (tgt)
          PH_ST_SDA: sda_drv_nxt = 1'b1;
          PH_ST_SCL: scl_drv_nxt = 1'b1;
          PH_TX_SET: begin
            scl_drv_nxt = 1'b1;
            sda_drv_nxt = !tx_bit;
          end
          PH_TX_HI1: scl_drv_nxt = 1'b0;
          PH_TX_LO:  scl_drv_nxt = 1'b1;
          PH_RX_SET: begin
            scl_drv_nxt = 1'b1;
            sda_drv_nxt = 1'b0;
          end
          PH_RX_UP:  scl_drv_nxt = 1'b0;
          PH_RX_LO:  scl_drv_nxt = 1'b1;
          PH_SP_SDA: begin
            scl_drv_nxt = 1'b1;
            sda_drv_nxt = 1'b1;
          end
          PH_SP_HI1: scl_drv_nxt = 1'b0;
          PH_SP_END: sda_drv_nxt = 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Build the result transaction from the post-step state
  always_comb begin
    res.scl_low   = scl_drv_nxt;
    res.sda_low   = sda_drv_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.read_byte = rx_byte_nxt;
    res.ack_bit   = ack_nxt;
  end

  // Update sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      unit_cnt_r  <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      nack_r      <= 1'b0;
      scl_drv_r   <= 1'b0;
      sda_drv_r   <= 1'b0;
      ack_r       <= 1'b0;
      read_mode_r <= 1'b0;
      rx_byte_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      unit_cnt_r  <= unit_cnt_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      nack_r      <= nack_nxt;
      scl_drv_r   <= scl_drv_nxt;
      sda_drv_r   <= sda_drv_nxt;
      ack_r       <= ack_nxt;
      read_mode_r <= read_mode_nxt;
      rx_byte_r   <= rx_byte_nxt;
    end
  end

endmodule

// ----- rtl/i2cm_outq.sv -----
// Result queue: holds finished result transactions until they are popped.
module i2cm_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cm_pkg::result_t res_in,
  output logic              ready,
  input  logic              pop,
  output logic              empty,
  output i2cm_pkg::result_t res_out
);
  import i2cm_pkg::*;

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              wr_en;
  logic              rd_en;

  assign ready   = (cnt_r != QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_en   = push && ready;
  assign rd_en   = pop && !empty;
  assign res_out = mem_r[rd_ptr_r];

  // Store the result
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= res_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/i2c_master_bit_engine_top.sv -----
// Top level of the I2C master bit engine: front queue, sequencer, result queue.
//
//   channel   direction  handshake          fields
//   in_       input      in_push / in_full  func, data_byte, send_nack, scl_in, sda_in
//   out_      output     out_pop / out_empty scl_low, sda_low, busy_res, done_res,
//                                            read_byte, ack_bit
//   cfg_      input      cfg_wr_en          cfg_wr_data (unit_ticks)
//
// One transaction per clock in steady state; a result reaches the out_ ports through
// the input queue slot, then the sequencer step into the result queue. The
// sequencer takes one step per transaction, so bus timing counts accepted
// transactions; a stall on either channel holds it. Both queues are two
// entries deep; the sequencer waits while the input queue is empty or the result
// queue is full, and in_full rises only when the input queue fills behind it.
// Reset (rst_n low, synchronous) empties both queues, sets unit_ticks to 1 and
// releases both bus lines.
module i2c_master_bit_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_send_nack,
  input  logic       in_scl_in,
  input  logic       in_sda_in,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_scl_low,
  output logic       out_sda_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_byte,
  output logic       out_ack_bit
);
  import i2cm_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    res_ready;
  logic    res_push;
  result_t res;
  result_t res_out;

  // Accept and classify input transactions
  i2cm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .func       (in_func),
    .data_byte  (in_data_byte),
    .send_nack  (in_send_nack),
    .scl_in     (in_scl_in),
    .sda_in     (in_sda_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Run the bus sequencer
  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .res_ready   (res_ready),
    .res_push    (res_push),
    .res         (res)
  );

  // Hold results until popped
  i2cm_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .res_in  (res),
    .ready   (res_ready),
    .pop     (out_pop),
    .empty   (out_empty),
    .res_out (res_out)
  );

  assign out_scl_low   = res_out.scl_low;
  assign out_sda_low   = res_out.sda_low;
  assign out_busy_res  = res_out.busy_res;
  assign out_done_res  = res_out.done_res;
  assign out_read_byte = res_out.read_byte;
  assign out_ack_bit   = res_out.ack_bit;

endmodule

// ----- rtl/i2cm_checker.sv -----
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_scl_low,
  input logic       out_sda_low,
  input logic       out_busy_res,
  input logic       out_done_res
);

  // Queues come out of reset empty
  a_empty_after_reset: assert property (
    @(posedge clk) !$past(rst_n) && rst_n |-> out_empty && !in_full
  ) else $error("queues not empty after reset");

  // A completed command leaves the engine idle
  a_done_not_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_empty && out_done_res |-> !out_busy_res
  ) else $error("done reported while busy");

  // Two consecutive results never both report completion
  a_done_single: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && out_done_res |=> out_empty || !out_done_res
  ) else $error("done on two consecutive results");

  // An idle engine never drives SDA low while SCL is released
  // (start ends with both low, stop and reset leave both released)
  a_idle_lines: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_empty && !out_busy_res |-> !(out_sda_low && !out_scl_low)
  ) else $error("idle with SDA held low under released SCL");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_scl_low  (out_scl_low),
  .out_sda_low  (out_sda_low),
  .out_busy_res (out_busy_res),
  .out_done_res (out_done_res)
);
